// ----- hdl/jtag_sequence_shift_engine_assert.svh -----
// ----------------------------------------------------------------------------
// jtag_sequence_shift_engine assertion macros
// Clocked assertion helpers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef JTAG_SEQUENCE_SHIFT_ENGINE_ASSERT_SVH
`define JTAG_SEQUENCE_SHIFT_ENGINE_ASSERT_SVH

`ifndef SYNTH
`define JSSE_ASSERT_CLK(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define JSSE_ASSERT_NEVER(lbl, ck, rs, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) else $error(msg);
`else
`define JSSE_ASSERT_CLK(lbl, ck, rs, prop, msg)
`define JSSE_ASSERT_NEVER(lbl, ck, rs, cond, msg)
`endif

`endif

// ----- hdl/jsse_pkg.sv -----
// ----------------------------------------------------------------------------
// jsse_pkg
// Types, constants and helpers shared by the JTAG sequence shift engine.
// ----------------------------------------------------------------------------
package jsse_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [5:0] INFO_CYC_MASK = 6'h3f;
  localparam logic [6:0] CYC_ZERO_MEANS = 7'd64;
  localparam logic [3:0] LANE_BITS = 4'd8;

  localparam logic KIND_SHIFT  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam logic ST_OK       = 1'b0;

  typedef enum logic [1:0] {
    PH_COUNT = 2'd0,
    PH_INFO  = 2'd1,
    PH_DATA  = 2'd2,
    PH_SKIP  = 2'd3
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic       tms_level;
    logic [3:0] bit_count;
    logic [7:0] tdi_bits;
    logic [7:0] tdo_byte;
    logic       capture;
    logic       status;
    logic       last;
  } res_t;

  // up to two results per accepted beat, packed from r0 up
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [7:0] lane_mask(input logic [3:0] cnt);
    logic [8:0] m;
    m = (9'd1 << cnt) - 9'd1;
    return (cnt >= LANE_BITS) ? 8'hff : m[7:0];
  endfunction

endpackage

// ----- hdl/jsse_parse.sv -----
// ----------------------------------------------------------------------------
// jsse_parse
// Command byte parser: tracks phase and counters, forms shift/status results.
// ----------------------------------------------------------------------------
`include "jtag_sequence_shift_engine_assert.svh"

module jsse_parse (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  logic           acc,
  input  logic [7:0]     req_byte,
  input  logic [7:0]     tdo_sample,
  output jsse_pkg::push_t push
);
  import jsse_pkg::*;

  logic       port_is_jtag;
  phase_t     phase, phase_next;
  logic [7:0] sequences_left, sequences_left_next;
  logic [6:0] cycles_left, cycles_left_next;
  logic       held_tms, held_tms_next;
  logic       capture_on, capture_on_next;
  logic       error_seen, error_seen_next;

  logic [3:0] cnt;
  logic [7:0] mask;
  logic [6:0] cyc_dec;
  logic [7:0] seq_dec;
  push_t      push_c;

  assign cnt     = (cycles_left > 7'd8) ? LANE_BITS : cycles_left[3:0];
  assign mask    = lane_mask(cnt);
  assign cyc_dec = cycles_left - {3'b000, cnt};
  assign seq_dec = sequences_left - 8'd1;

  always_comb begin
    res_t rec;
    res_t stat;
    logic emit_rec;
    logic emit_stat;
    logic done;

    phase_next          = phase;
    sequences_left_next = sequences_left;
    cycles_left_next    = cycles_left;
    held_tms_next       = held_tms;
    capture_on_next     = capture_on;
    error_seen_next     = error_seen;
    rec       = '0;
    stat      = '0;
    emit_rec  = 1'b0;
    emit_stat = 1'b0;
    done      = (cyc_dec == 7'd0) && (sequences_left <= 8'd1);
    push_c    = '0;

    unique case (phase)
      PH_COUNT: begin
        error_seen_next     = 1'b0;
        sequences_left_next = req_byte;
        if (req_byte == 8'd0) begin
          emit_stat = 1'b1;
          stat.kind = KIND_STATUS;
          stat.status = ST_OK;
          stat.last = 1'b1;
        end else begin
          phase_next = PH_INFO;
        end
      end
      PH_INFO: begin
        cycles_left_next = ((req_byte[5:0] & INFO_CYC_MASK) == 6'd0) ?
                           CYC_ZERO_MEANS : {1'b0, req_byte[5:0]};
        held_tms_next   = req_byte[6];
        capture_on_next = req_byte[7];
        if (port_is_jtag) begin
          phase_next = PH_DATA;
        end else begin
          error_seen_next = 1'b1;
          phase_next      = PH_SKIP;
        end
      end
      PH_DATA, PH_SKIP: begin
        cycles_left_next = cyc_dec;
        if (phase == PH_DATA && cnt != 4'd0) begin
          emit_rec      = 1'b1;
          rec.kind      = KIND_SHIFT;
          rec.tms_level = held_tms;
          rec.bit_count = cnt;
          rec.tdi_bits  = req_byte & mask;
          rec.tdo_byte  = tdo_sample & mask;
          rec.capture   = capture_on;
          rec.status    = ST_OK;
          rec.last      = !done;
        end
        if (cyc_dec == 7'd0) begin
          sequences_left_next = seq_dec;
          if (seq_dec == 8'd0) begin
            emit_stat   = 1'b1;
            stat.kind   = KIND_STATUS;
            stat.status = error_seen;
            stat.last   = 1'b1;
            phase_next  = PH_COUNT;
          end else begin
            phase_next = PH_INFO;
          end
        end
      end
      default: phase_next = PH_COUNT;
    endcase

    if (emit_rec) begin
      push_c.r0 = rec;
      push_c.r1 = stat;
    end else begin
      push_c.r0 = stat;
    end
    push_c.n = {1'b0, emit_rec} + {1'b0, emit_stat};
    if (!acc) begin
      push_c.n = 2'd0;
    end
  end

  assign push = push_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_is_jtag   <= 1'b1;
      phase          <= PH_COUNT;
      sequences_left <= '0;
      cycles_left    <= '0;
      held_tms       <= 1'b0;
      capture_on     <= 1'b0;
      error_seen     <= 1'b0;
    end else begin
      if (cfg_we) begin
        port_is_jtag <= cfg_wdata;
      end
      if (acc) begin
        phase          <= phase_next;
        sequences_left <= sequences_left_next;
        cycles_left    <= cycles_left_next;
        held_tms       <= held_tms_next;
        capture_on     <= capture_on_next;
        error_seen     <= error_seen_next;
      end
    end
  end

  // a status result always closes the command
  `JSSE_ASSERT_CLK(a_status_ends_cmd, clk, rst, (push.n != 2'd0 && (push.r0.kind == KIND_STATUS || (push.n == 2'd2 && push.r1.kind == KIND_STATUS))) |=> phase == PH_COUNT, "status result without return to count phase")
  // skipped bytes never produce a shift record
  `JSSE_ASSERT_NEVER(a_skip_silent, clk, rst, acc && phase == PH_SKIP && push.n != 2'd0 && push.r0.kind == KIND_SHIFT, "shift record while skipping")
  // data phases always have cycles to clock
  `JSSE_ASSERT_NEVER(a_cyc_live, clk, rst, (phase == PH_DATA || phase == PH_SKIP) && cycles_left == 7'd0, "data phase with no cycles left")

endmodule

// ----- hdl/jsse_outq.sv -----
// ----------------------------------------------------------------------------
// jsse_outq
// Four-entry result queue: takes up to two results a cycle, drains one while out_ready is high.
// ----------------------------------------------------------------------------
`include "jtag_sequence_shift_engine_assert.svh"

module jsse_outq (
  input  logic            clk,
  input  logic            rst,
  input  jsse_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output jsse_pkg::res_t  out_res
);
  import jsse_pkg::*;

  res_t           q [QDEPTH];
  logic [QAW-1:0] head;
  logic [QAW-1:0] tail;
  logic [QCW-1:0] count;
  logic           pop;
  logic [QAW-1:0] tail1;

  assign out_valid = (count != '0);
  assign out_res   = q[head];
  assign pop       = out_valid && out_ready;
  // room for a worst-case beat of two results
  assign room      = (count <= QCW'(QDEPTH - 2));
  assign tail1     = tail + QAW'(1);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q[tail] <= push.r0;
    end
    if (push.n == 2'd2) begin
      q[tail1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + QAW'(push.n);
      head  <= head + QAW'(pop);
      count <= count + QCW'(push.n) - QCW'(pop);
    end
  end

  `JSSE_ASSERT_NEVER(a_no_overflow, clk, rst, count > QCW'(QDEPTH), "queue count beyond depth")
  `JSSE_ASSERT_NEVER(a_push_room, clk, rst, push.n != 2'd0 && !room, "push without room")
  `JSSE_ASSERT_CLK(a_count_track, clk, rst, !$past(rst) |-> count == $past(count) + QCW'($past(push.n)) - QCW'($past(pop)), "queue count out of step")

endmodule

// ----- hdl/jtag_sequence_shift_engine.sv -----
// ----------------------------------------------------------------------------
// jtag_sequence_shift_engine: accepts one request beat per cycle when room allows;
// results are registered into a 4-deep queue, one result beat out per ready cycle.
// Sync active-high reset: count phase, counters clear, port_is_jtag = 1.
// ----------------------------------------------------------------------------
module jtag_sequence_shift_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,      // port_is_jtag
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // request_byte[7:0], tdo_sample[15:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // tms_level, bit_count[4:1], tdi_bits[12:5],
                                      // tdo_byte[20:13], capture, status, pad
  output logic        m_axis_tuser,   // kind
  output logic        m_axis_tlast
);
  import jsse_pkg::*;

  logic  acc;
  logic  room;
  push_t push;
  res_t  res;

  assign s_axis_tready = room;
  assign acc = s_axis_tvalid && room;

  jsse_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .req_byte  (s_axis_tdata[7:0]),
    .tdo_sample(s_axis_tdata[15:8]),
    .push      (push)
  );

  jsse_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_res  (res)
  );

  assign m_axis_tdata = {1'b0, res.status, res.capture, res.tdo_byte, res.tdi_bits,
                         res.bit_count, res.tms_level};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

// ----- test/jtag_shift_record_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jtag_shift_record_checker
// Watches the request and result streams of the JTAG sequence shift engine,
// tracks the command parse state, and checks each result beat in order
// against the shift records and status beats the request bytes call for.
// ----------------------------------------------------------------------------
module jtag_shift_record_checker
  import jsse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // request_byte[7:0], tdo_sample[15:8]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // tms_level, bit_count[4:1], tdi_bits[12:5],
                                      // tdo_byte[20:13], capture, status, pad
  input  logic        m_axis_tuser,   // kind
  input  logic        m_axis_tlast,
  output int          mismatch_count,
  output int          outstanding
);

  phase_t     parse_phase;
  logic [7:0] seqs_left;
  logic [6:0] cycles_left;
  logic       tms_hold;
  logic       capture_hold;
  logic       error_flag;
  logic       port_jtag;
  res_t       records_due[$];
  int         errors = 0;

  task automatic push_status();
    res_t r;
    r = '0;
    r.kind   = KIND_STATUS;
    r.status = error_flag;
    r.last   = 1'b1;
    records_due.push_back(r);
  endtask

  // one request byte through the command parser
  task automatic parse_request_byte(input logic [7:0] rb, input logic [7:0] tdo);
    logic [3:0] nbits;
    logic [7:0] keep;
    logic       closing;
    res_t       r;
    case (parse_phase)
      PH_COUNT: begin
        error_flag = 1'b0;
        seqs_left  = rb;
        if (rb == 8'd0) push_status();
        else parse_phase = PH_INFO;
      end
      PH_INFO: begin
        cycles_left  = (rb[5:0] == 6'd0) ? 7'd64 : {1'b0, rb[5:0]};
        tms_hold     = rb[6];
        capture_hold = rb[7];
        if (port_jtag) begin
          parse_phase = PH_DATA;
        end else begin
          error_flag  = 1'b1;
          parse_phase = PH_SKIP;
        end
      end
      default: begin
        nbits       = (cycles_left > 7'd8) ? 4'd8 : cycles_left[3:0];
        keep        = 8'hff >> (4'd8 - nbits);
        cycles_left = cycles_left - {3'd0, nbits};
        closing     = (cycles_left == 7'd0) && (seqs_left <= 8'd1);
        if (parse_phase == PH_DATA) begin
          r           = '0;
          r.kind      = KIND_SHIFT;
          r.tms_level = tms_hold;
          r.bit_count = nbits;
          r.tdi_bits  = rb & keep;
          r.tdo_byte  = tdo & keep;
          r.capture   = capture_hold;
          r.status    = ST_OK;
          r.last      = !closing;
          records_due.push_back(r);
        end
        if (cycles_left == 7'd0) begin
          seqs_left = seqs_left - 8'd1;
          if (seqs_left == 8'd0) begin
            push_status();
            parse_phase = PH_COUNT;
          end else begin
            parse_phase = PH_INFO;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    logic bad;
    if (rst) begin
      parse_phase  = PH_COUNT;
      seqs_left    = '0;
      cycles_left  = '0;
      tms_hold     = 1'b0;
      capture_hold = 1'b0;
      error_flag   = 1'b0;
      port_jtag    = 1'b1;
      records_due.delete();
    end else begin
      if (cfg_we) port_jtag = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        parse_request_byte(s_axis_tdata[7:0], s_axis_tdata[15:8]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind      = m_axis_tuser;
        got.tms_level = m_axis_tdata[0];
        got.bit_count = m_axis_tdata[4:1];
        got.tdi_bits  = m_axis_tdata[12:5];
        got.tdo_byte  = m_axis_tdata[20:13];
        got.capture   = m_axis_tdata[21];
        got.status    = m_axis_tdata[22];
        got.last      = m_axis_tlast;
        if (records_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result beat with nothing expected: kind=%0d cnt=%0d last=%0d",
                     $realtime, got.kind, got.bit_count, got.last);
        end else begin
          want = records_due.pop_front();
          bad = (got.kind      !== want.kind)      || (got.tms_level !== want.tms_level) ||
                (got.bit_count !== want.bit_count) || (got.tdi_bits  !== want.tdi_bits)  ||
                (got.tdo_byte  !== want.tdo_byte)  || (got.capture   !== want.capture)   ||
                (got.status    !== want.status)    || (got.last      !== want.last);
          if (bad) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  want kind=%0d tms=%0d cnt=%0d tdi=%02h tdo=%02h cap=%0d st=%0d last=%0d",
                       want.kind, want.tms_level, want.bit_count, want.tdi_bits,
                       want.tdo_byte, want.capture, want.status, want.last);
              $display("  got  kind=%0d tms=%0d cnt=%0d tdi=%02h tdo=%02h cap=%0d st=%0d last=%0d",
                       got.kind, got.tms_level, got.bit_count, got.tdi_bits,
                       got.tdo_byte, got.capture, got.status, got.last);
            end
          end
        end
      end
    end
    mismatch_count <= errors;
    outstanding    <= records_due.size();
  end

endmodule

// ----- test/tb_jtag_sequence_shift_engine.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_jtag_sequence_shift_engine
// Drives JTAG sequence commands into the shift engine: a directed set of
// edge cases, then random commands under several port settings, with random
// gaps on both streams and one long result hold-off. The checker judges beats.
// ----------------------------------------------------------------------------
module tb_jtag_sequence_shift_engine;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 4;
  localparam int TAIL        = 8;
  localparam int PHASE_ITEMS = 56;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_we        = 1'b0;
  logic        cfg_wdata     = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [15:0] s_axis_tdata  = 16'h0000;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int mismatch_count;
  int outstanding;
  int idle_run      = 0;
  int beats_sent    = 0;
  int records_taken = 0;

  always #5 clk = ~clk;

  jtag_sequence_shift_engine uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  jtag_shift_record_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // cycles in a row with no beat on either stream
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
  end

  initial begin : watchdog
    while (idle_run < IDLE_LIMIT) @(posedge clk);
    $display("jtag_sequence_shift_engine regression: fail");
    $finish;
  end

  // result side: random stalls, bursts with none, one long hold-off
  initial begin : result_sink
    int gap;
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && records_taken == 30) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end else begin
        gap = (records_taken % 50 < 10) ? 0 : $urandom_range(0, 14);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      records_taken++;
    end
  end

  task automatic send_beat(input logic [7:0] rb, input logic [7:0] tdo);
    int gap;
    gap = (beats_sent % 64 < 12) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {tdo, rb};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    beats_sent++;
  endtask

  // stop offering and let every expected result come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_port(input logic is_jtag);
    cfg_wdata <= is_jtag;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // count byte, then per sequence an info byte and its TDI bytes
  task automatic send_command(input int n_seq, input bit short_only);
    int         cyc;
    int         nbytes;
    int         pick;
    logic [7:0] info;
    send_beat(n_seq[7:0], 8'($urandom_range(0, 255)));
    for (int s = 0; s < n_seq; s++) begin
      pick = $urandom_range(0, 9);
      if (short_only || pick < 6) cyc = $urandom_range(1, 8);
      else if (pick < 8)          cyc = $urandom_range(9, 63);
      else if (pick == 8)         cyc = 0;
      else                        cyc = $urandom_range(0, 63);
      info[5:0] = cyc[5:0];
      info[6]   = 1'($urandom_range(0, 1));
      info[7]   = 1'($urandom_range(0, 1));
      nbytes    = ((cyc == 0 ? 64 : cyc) + 7) / 8;
      send_beat(info, 8'($urandom_range(0, 255)));
      for (int b = 0; b < nbytes; b++)
        send_beat(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int pick;
    int n_seq;
    int phase_start;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    set_port(1'b1);

    // empty command: status comes at once
    send_beat(8'h00, 8'hff);
    // one sequence of a single cycle
    send_beat(8'h01, 8'h00);
    send_beat(8'h01, 8'h00);
    send_beat(8'hff, 8'hff);
    // two sequences, port leaves JTAG between them: second one is skipped
    send_beat(8'h02, 8'h00);
    send_beat(8'hc9, 8'h00);        // tms high, capture
    send_beat(8'ha5, 8'h5a);
    send_beat(8'hff, 8'hff);
    drain_results();
    set_port(1'b0);
    send_beat(8'h48, 8'h00);        // tms high
    send_beat(8'hff, 8'hff);
    drain_results();
    set_port(1'b1);
    // one sequence, info cycle field zero
    send_beat(8'h01, 8'hff);
    send_beat(8'h00, 8'hff);
    for (int i = 0; i < 8; i++)
      send_beat(i[0] ? 8'hff : 8'h00, i[0] ? 8'h00 : 8'hff);
    // one more single-sequence command, capture on, tms low
    send_beat(8'h01, 8'h00);
    send_beat(8'h88, 8'h00);
    send_beat(8'h3c, 8'hc3);

    // longest command, short sequences
    drain_results();
    send_command(255, 1'b1);

    for (int ph = 1; ph < 8; ph++) begin
      drain_results();
      set_port((ph % 3 == 1) ? 1'b0 : 1'b1);
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 19);
        if (pick == 0)       n_seq = 0;
        else if (pick == 19) n_seq = $urandom_range(5, 12);
        else                 n_seq = $urandom_range(1, 4);
        send_command(n_seq, 1'b0);
      end
    end

    drain_results();
    repeat (TAIL) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("jtag_sequence_shift_engine regression: pass");
    else
      $display("jtag_sequence_shift_engine regression: fail");
    $finish;
  end

endmodule
